>>> src/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types and codes for the HMM sequence sampler: request and result
// payloads, mode codes, register indexes and controller/datapath signals.
// ----------------------------------------------------------------------------
package hss_pkg;

    localparam int PROB_W   = 17;
    localparam int DRAW_W   = 16;
    localparam int FIELD_W  = 4;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_WR_START = 2'd0;
    localparam logic [1:0] MODE_WR_TRANS = 2'd1;
    localparam logic [1:0] MODE_WR_EMIT  = 2'd2;
    localparam logic [1:0] MODE_GENERATE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_IN_USE = 2'd1;

    localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]         mode;
        logic [FIELD_W-1:0] row_index;
        logic [FIELD_W-1:0] column_index;
        logic [PROB_W-1:0]  probability;
        logic [DRAW_W-1:0]  draw_hidden;
        logic [DRAW_W-1:0]  draw_symbol;
        logic               restart;
    } t_request;

    typedef struct packed {
        logic [FIELD_W-1:0] hidden_state;
        logic [FIELD_W-1:0] observed_symbol;
        logic [1:0]         fell_through;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic write_en;
        logic load_req;
        logic init_walk;
        logic init_sym;
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic walk_done;
    } t_status;

endpackage

>>> src/hss_ctrl.sv
// ----------------------------------------------------------------------------
// hss_ctrl
// Sequencer for the sampler: accepts requests, runs the hidden walk and then
// the symbol walk for a generate request, and pulses the result strobe.
// ----------------------------------------------------------------------------
module hss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_mode,
    input  hss_pkg::t_status i_status,
    output hss_pkg::t_ctrl   o_ctrl,
    output logic             o_busy,
    output logic             o_strobe
);
    import hss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_HWALK = 3'b010,
        ST_SWALK = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;
    logic   accept;

    assign o_busy   = (r_state != ST_IDLE);
    assign accept   = i_start && (r_state == ST_IDLE);
    assign o_strobe = r_strobe;

    always_comb begin
        n_state         = r_state;
        n_strobe        = 1'b0;
        o_ctrl.write_en = accept && (i_mode != MODE_GENERATE);
        o_ctrl.load_req = accept && (i_mode == MODE_GENERATE);
        o_ctrl.init_walk = 1'b0;
        o_ctrl.init_sym  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (o_ctrl.load_req) begin
                    o_ctrl.init_walk = 1'b1;
                    n_state          = ST_HWALK;
                end
            end
            ST_HWALK: begin
                if (i_status.walk_done) begin
                    o_ctrl.init_walk = 1'b1;
                    o_ctrl.init_sym  = 1'b1;
                    n_state          = ST_SWALK;
                end
            end
            ST_SWALK: begin
                if (i_status.walk_done) begin
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

endmodule

>>> src/hss_datapath.sv
// ----------------------------------------------------------------------------
// hss_datapath
// Probability tables, configuration registers and the cumulative walk unit.
// One table entry is read per cycle; the running sum is checked against the
// draw in the cycle after each read.
// ----------------------------------------------------------------------------
module hss_datapath #(
    parameter int MAX_HIDDEN  = 16,
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hss_pkg::t_ctrl                      i_ctrl,
    input  hss_pkg::t_request                   i_request,
    input  logic                                i_cfg_we,
    input  logic [hss_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hss_pkg::CFG_W-1:0]           i_cfg_data,
    output hss_pkg::t_status                    o_status,
    output hss_pkg::t_result                    o_result
);
    import hss_pkg::*;

    localparam int HW   = $clog2(MAX_HIDDEN);
    localparam int MAXN = (MAX_HIDDEN > MAX_SYMBOLS) ? MAX_HIDDEN : MAX_SYMBOLS;
    localparam int CW   = $clog2(MAXN + 1);
    localparam int SW   = PROB_W + $clog2(MAXN);
    localparam int TD   = MAX_HIDDEN * MAX_HIDDEN;
    localparam int ED   = MAX_HIDDEN * MAX_SYMBOLS;
    localparam int TAW  = $clog2(TD);
    localparam int EAW  = $clog2(ED);

    function automatic logic [CW-1:0] clamp_count(logic [CFG_W-1:0] v, int lim);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if (32'(v) > lim) begin
            res = CW'(lim);
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    logic [PROB_W-1:0] mem_start [MAX_HIDDEN];
    logic [PROB_W-1:0] mem_trans [TD];
    logic [PROB_W-1:0] mem_emit  [ED];

    logic [PROB_W-1:0] r_start_q, r_trans_q, r_emit_q;

    logic [CFG_W-1:0] r_nh_cfg, r_ns_cfg;
    t_request         r_req;
    logic             r_active, r_sym, r_pend;
    logic [CW-1:0]    r_rd_idx, r_pend_idx;
    logic [SW-1:0]    r_sum;
    logic [HW-1:0]    r_hidden, r_prev;
    logic             r_miss_h;
    t_result          r_result;

    logic             wr_start, wr_trans, wr_emit;
    logic [TAW-1:0]   wr_taddr, rd_taddr;
    logic [EAW-1:0]   wr_eaddr, rd_eaddr;
    logic [HW-1:0]    rd_saddr;
    logic [CW-1:0]    nh, ns, n_cur;
    logic [PROB_W-1:0] rd_data;
    logic [SW-1:0]    sum_next, draw;
    logic             issue, match, last, done;

    // Write decode: drop writes outside the table
    assign wr_start = i_ctrl.write_en && (i_request.mode == MODE_WR_START)
                      && (32'(i_request.row_index) < MAX_HIDDEN);
    assign wr_trans = i_ctrl.write_en && (i_request.mode == MODE_WR_TRANS)
                      && (32'(i_request.row_index) < MAX_HIDDEN)
                      && (32'(i_request.column_index) < MAX_HIDDEN);
    assign wr_emit  = i_ctrl.write_en && (i_request.mode == MODE_WR_EMIT)
                      && (32'(i_request.row_index) < MAX_HIDDEN)
                      && (32'(i_request.column_index) < MAX_SYMBOLS);
    assign wr_taddr = TAW'(32'(i_request.row_index) * MAX_HIDDEN
                           + 32'(i_request.column_index));
    assign wr_eaddr = EAW'(32'(i_request.row_index) * MAX_SYMBOLS
                           + 32'(i_request.column_index));

    assign rd_saddr = HW'(r_rd_idx);
    assign rd_taddr = TAW'(32'(r_prev) * MAX_HIDDEN + 32'(r_rd_idx));
    assign rd_eaddr = EAW'(32'(r_hidden) * MAX_SYMBOLS + 32'(r_rd_idx));

    always_ff @(posedge i_clk) begin
        if (wr_start) begin
            mem_start[HW'(i_request.row_index)] <= i_request.probability;
        end
        r_start_q <= mem_start[rd_saddr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_trans) begin
            mem_trans[wr_taddr] <= i_request.probability;
        end
        r_trans_q <= mem_trans[rd_taddr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_emit) begin
            mem_emit[wr_eaddr] <= i_request.probability;
        end
        r_emit_q <= mem_emit[rd_eaddr];
    end

    // Walk compare
    assign nh       = clamp_count(r_nh_cfg, MAX_HIDDEN);
    assign ns       = clamp_count(r_ns_cfg, MAX_SYMBOLS);
    assign n_cur    = r_sym ? ns : nh;
    assign issue    = r_active && (r_rd_idx < n_cur);
    assign rd_data  = r_sym ? r_emit_q : (r_req.restart ? r_start_q : r_trans_q);
    assign sum_next = r_sum + SW'(rd_data);
    assign draw     = r_sym ? SW'(r_req.draw_symbol) : SW'(r_req.draw_hidden);
    assign match    = (draw <= sum_next);
    assign last     = (r_pend_idx == n_cur - CW'(1));
    assign done     = r_active && r_pend && (match || last);

    assign o_status.walk_done = done;
    assign o_result           = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nh_cfg <= CFG_COUNT_RESET;
            r_ns_cfg <= CFG_COUNT_RESET;
            r_active <= 1'b0;
            r_pend   <= 1'b0;
            r_prev   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HIDDEN_IN_USE:  r_nh_cfg <= i_cfg_data;
                    CFG_SYMBOLS_IN_USE: r_ns_cfg <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_ctrl.init_walk) begin
                r_active <= 1'b1;
                r_pend   <= 1'b0;
            end else if (done) begin
                r_active <= 1'b0;
                r_pend   <= 1'b0;
            end else begin
                r_pend <= issue;
            end

            // Advance the chain: the symbol walk result ends the step
            if (done && r_sym) begin
                r_prev <= r_hidden;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_req) begin
            r_req <= i_request;
        end

        if (i_ctrl.init_walk) begin
            r_sym    <= i_ctrl.init_sym;
            r_rd_idx <= '0;
            r_sum    <= '0;
        end else begin
            if (issue) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (r_pend) begin
                r_sum <= sum_next;
            end
        end
        r_pend_idx <= r_rd_idx;

        if (done && !r_sym) begin
            r_hidden <= HW'(r_pend_idx);
            r_miss_h <= !match;
        end

        if (done && r_sym) begin
            r_result.hidden_state    <= FIELD_W'(32'(r_hidden));
            r_result.observed_symbol <= FIELD_W'(32'(r_pend_idx));
            r_result.fell_through    <= {!match, r_miss_h};
        end
    end

endmodule

>>> src/hmm_sequence_sampler.sv
// ----------------------------------------------------------------------------
// hmm_sequence_sampler
// Hidden Markov model sampler: table loading and one time step per generate
// request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Write requests
// (start, transition, emission entry) complete in the cycle they are taken
// and produce no result. A generate request walks the running sum of the
// start row (restart) or of the previous state's transition row, one entry a
// cycle from a registered table read, then walks the chosen state's
// emission row the same way. Each walk stops at the first entry whose
// running sum reaches the draw, or at its last entry, with the hidden and
// symbol counts taken after clamping to 1 .. table size. Busy stays high
// until the symbol walk stops, and the result strobe pulses in the same
// cycle that busy falls. The strobe is high for exactly one cycle and the
// receiver cannot stall it. Table entries must be written before a walk
// reads them; there is no clearing pass.
// Configuration writes are always ready and must only be issued while idle.
// ----------------------------------------------------------------------------
module hmm_sequence_sampler #(
    parameter int MAX_HIDDEN  = 16,
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  hss_pkg::t_request                i_request,
    output logic                             o_result_strobe,
    output hss_pkg::t_result                 o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hss_pkg::CFG_W-1:0]        i_cfg_data
);
    import hss_pkg::*;

    t_ctrl   ctrl;
    t_status status;

    assign o_cfg_ready = 1'b1;

    hss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_request.mode),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy),
        .o_strobe (o_result_strobe)
    );

    hss_datapath #(
        .MAX_HIDDEN  (MAX_HIDDEN),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_request   (i_request),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_result    (o_result)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HMM sequence sampler. Loads every table entry,
// runs a short directed set, then random requests under several count
// settings. Expected steps come from a local model of the walks and are
// compared field by field against each result strobe.
// ----------------------------------------------------------------------------
module tb_top;
    import hss_pkg::*;

    localparam int N_STATES         = 16;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int RANDOM_PER_PHASE = 95;
    localparam int NUM_PHASES       = 8;
    localparam int DRAIN_CYCLES     = 48;

    typedef logic [N_STATES-1:0][PROB_W-1:0] t_prob_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_request             i_request   = '0;
    logic                 o_result_strobe;
    t_result              o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_HIDDEN_IN_USE;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    hmm_sequence_sampler #(
        .MAX_HIDDEN (N_STATES),
        .MAX_SYMBOLS(N_STATES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Sampler model state
    t_prob_row          start_row;
    t_prob_row          trans_rows [N_STATES];
    t_prob_row          emit_rows  [N_STATES];
    logic [FIELD_W-1:0] last_hidden  = '0;
    logic [CFG_W-1:0]   hidden_count = CFG_COUNT_RESET;
    logic [CFG_W-1:0]   symbol_count = CFG_COUNT_RESET;

    t_request pending_requests [$];
    t_result  expected_steps   [$];
    int       error_count    = 0;
    int       cycle_count    = 0;
    logic     no_gap_stretch = 1'b0;

    function automatic int clamp_count(logic [CFG_W-1:0] value);
        if (value == 0) return 1;
        if (value > N_STATES) return N_STATES;
        return int'(value);
    endfunction

    // First index whose running sum reaches the draw; last index on a miss.
    function automatic int walk_running_sum(t_prob_row row, int count,
                                            logic [DRAW_W-1:0] draw,
                                            output logic missed);
        logic [31:0] sum;
        sum = '0;
        for (int k = 0; k < count; k++) begin
            sum = sum + 32'(row[k]);
            if (32'(draw) <= sum) begin
                missed = 1'b0;
                return k;
            end
        end
        missed = 1'b1;
        return count - 1;
    endfunction

    function automatic void predict_request(t_request req);
        t_result   res;
        t_prob_row hrow;
        logic      miss_h;
        logic      miss_s;
        int        h;
        int        s;
        case (req.mode)
            MODE_WR_START: start_row[req.row_index] = req.probability;
            MODE_WR_TRANS: trans_rows[req.row_index][req.column_index] = req.probability;
            MODE_WR_EMIT:  emit_rows[req.row_index][req.column_index] = req.probability;
            default: begin
                hrow = req.restart ? start_row : trans_rows[last_hidden];
                h = walk_running_sum(hrow, clamp_count(hidden_count), req.draw_hidden,
                                     miss_h);
                s = walk_running_sum(emit_rows[h], clamp_count(symbol_count),
                                     req.draw_symbol, miss_s);
                last_hidden         = h[FIELD_W-1:0];
                res.hidden_state    = h[FIELD_W-1:0];
                res.observed_symbol = s[FIELD_W-1:0];
                res.fell_through    = {miss_s, miss_h};
                expected_steps.insert(expected_steps.size(), res);
            end
        endcase
    endfunction

    function automatic t_request random_request();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(t_request)-1:0];
    endfunction

    function automatic logic [PROB_W-1:0] rand_prob();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 17'd65536;
            2:       return PROB_W'($urandom_range(131071));
            default: return PROB_W'($urandom_range(8192));
        endcase
    endfunction

    function automatic logic [DRAW_W-1:0] rand_draw();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return DRAW_W'($urandom_range(65535));
        endcase
    endfunction

    // Unused fields carry random bits; the block must ignore them.
    task automatic add_write(logic [1:0] mode, logic [FIELD_W-1:0] row,
                             logic [FIELD_W-1:0] col, logic [PROB_W-1:0] prob);
        t_request r;
        r = random_request();
        r.mode         = mode;
        r.row_index    = row;
        r.column_index = col;
        r.probability  = prob;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    task automatic add_generate(logic restart, logic [DRAW_W-1:0] draw_h,
                                logic [DRAW_W-1:0] draw_s);
        t_request r;
        r = random_request();
        r.mode        = MODE_GENERATE;
        r.restart     = restart;
        r.draw_hidden = draw_h;
        r.draw_symbol = draw_s;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    task automatic add_random_item();
        logic [1:0] wmode;
        if ($urandom_range(99) < 72) begin
            add_generate($urandom_range(99) < 20, rand_draw(), rand_draw());
        end else begin
            case ($urandom_range(2))
                0:       wmode = MODE_WR_START;
                1:       wmode = MODE_WR_TRANS;
                default: wmode = MODE_WR_EMIT;
            endcase
            add_write(wmode, FIELD_W'($urandom_range(15)), FIELD_W'($urandom_range(15)),
                      rand_prob());
        end
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || expected_steps.size() != 0 || start)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HIDDEN_IN_USE) hidden_count = value;
        else symbol_count = value;
    endtask

    function automatic logic [CFG_W-1:0] phase_count(int phase, bit symbols);
        case (phase)
            0: return 5'd16;
            1: return 5'd1;
            2: return 5'd0;
            3: return 5'd31;
            4: return symbols ? 5'd16 : 5'd5;
            5: return symbols ? 5'd3 : 5'd16;
            default: return CFG_W'($urandom_range(31));
        endcase
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_request(i_request);
                pending_requests.delete(0);
            end
            if (start && busy) begin
                // hold the request until taken
            end else if (pending_requests.size() != 0 &&
                         (no_gap_stretch || $urandom_range(99) >= 31)) begin
                start     <= 1'b1;
                i_request <= pending_requests[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        logic    bad;
        if (i_rst_n && o_result_strobe) begin
            if (expected_steps.size() == 0) begin
                $display("%0t: unexpected result: hidden %0d symbol %0d fell_through %0d",
                         $time, o_result.hidden_state, o_result.observed_symbol,
                         o_result.fell_through);
                error_count++;
            end else begin
                want = expected_steps.pop_front();
                bad  = 1'b0;
                if (o_result.hidden_state !== want.hidden_state) begin
                    $display("%0t: hidden_state expected %0d actual %0d", $time,
                             want.hidden_state, o_result.hidden_state);
                    bad = 1'b1;
                end
                if (o_result.observed_symbol !== want.observed_symbol) begin
                    $display("%0t: observed_symbol expected %0d actual %0d", $time,
                             want.observed_symbol, o_result.observed_symbol);
                    bad = 1'b1;
                end
                if (o_result.fell_through !== want.fell_through) begin
                    $display("%0t: fell_through expected %0d actual %0d", $time,
                             want.fell_through, o_result.fell_through);
                    bad = 1'b1;
                end
                if (bad) error_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** hmm_sequence_sampler: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load every entry so no walk reads an unwritten one. Keep the start row
        // and emission row 15 below a total of 65535 to force misses below.
        for (int r = 0; r < N_STATES; r++) begin
            add_write(MODE_WR_START, FIELD_W'(r), FIELD_W'($urandom_range(15)),
                      PROB_W'($urandom_range(4000)));
            for (int c = 0; c < N_STATES; c++) begin
                add_write(MODE_WR_TRANS, FIELD_W'(r), FIELD_W'(c),
                          PROB_W'($urandom_range(8192)));
                add_write(MODE_WR_EMIT, FIELD_W'(r), FIELD_W'(c),
                          (r == N_STATES - 1) ? PROB_W'($urandom_range(4000))
                                              : PROB_W'($urandom_range(8192)));
            end
        end

        add_generate(1'b1, 16'd0, 16'd0);
        add_generate(1'b1, 16'hFFFF, 16'hFFFF);
        add_generate(1'b0, 16'hFFFF, 16'd0);
        add_generate(1'b0, 16'd0, 16'hFFFF);
        add_write(MODE_WR_START, 4'd0, 4'd15, 17'd65536);
        add_generate(1'b1, 16'hFFFF, 16'd1);
        add_write(MODE_WR_EMIT, 4'd0, 4'd0, 17'h1FFFF);
        add_generate(1'b1, 16'hFFFF, 16'hFFFF);
        add_write(MODE_WR_TRANS, 4'd0, 4'd0, 17'd0);
        add_write(MODE_WR_TRANS, 4'd0, 4'd1, 17'd65536);
        add_generate(1'b0, 16'd1, 16'd0);
        add_write(MODE_WR_TRANS, 4'd15, 4'd15, 17'h1FFFF);
        add_write(MODE_WR_EMIT, 4'd15, 4'd15, 17'd0);
        add_write(MODE_WR_START, 4'd15, 4'd0, 17'd0);
        add_generate(1'b0, 16'd32768, 16'd32768);
        add_generate(1'b0, 16'hFFFF, 16'd1);
        add_generate(1'b1, 16'd1, 16'hFFFE);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_config(CFG_HIDDEN_IN_USE, phase_count(p, 1'b0));
            write_config(CFG_SYMBOLS_IN_USE, phase_count(p, 1'b1));
            no_gap_stretch <= (p == 3);
            for (int k = 0; k < RANDOM_PER_PHASE; k++) add_random_item();
        end

        while (pending_requests.size() != 0 || expected_steps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_steps.size() == 0) begin
            $display("** hmm_sequence_sampler: PASSED **");
        end else begin
            $display("** hmm_sequence_sampler: FAILED **");
        end
        $finish;
    end

endmodule
